FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/cru_pkg.sv
// ----------------------------------------------------------------------------
// cru_pkg
// Widths, word layout and the stone-spread ROM contents for the
// composition rank/unrank core.
// ----------------------------------------------------------------------------
package cru_pkg;

    // Field widths
    localparam int PIT_W       = 6;
    localparam int PIT_COUNT   = 12;
    localparam int LAST_RANKED = 11;
    localparam int SIDE_PITS   = 6;
    localparam int PACK_W      = PIT_W * SIDE_PITS;     // 36
    localparam int REL_W       = PIT_W * PIT_COUNT;     // 72
    localparam int IDX_W       = 39;
    localparam int SUM_W       = 10;                    // 12 * 63 fits
    localparam int CNT_W       = 7;                     // up to 64
    localparam int PIDX_W      = 4;                     // pit number / pit count

    // Default stone limit
    localparam int STONE_LIMIT_DEF = 48;

    // ROM geometry: address = {stones, pits}
    localparam int STONE_ROWS = 64;
    localparam int ROM_AW     = PIT_W + PIDX_W;
    localparam int ROM_DEPTH  = 1 << ROM_AW;
    localparam int WAYS_W     = 45;                     // C(74,11) fits

    // Input word layout, lowest bit up
    localparam int IN_FIRST_LO  = 0;
    localparam int IN_SECOND_LO = IN_FIRST_LO + PACK_W;
    localparam int IN_MOVE_BIT  = IN_SECOND_LO + PACK_W;
    localparam int IN_CODE_LO   = IN_MOVE_BIT + 1;
    localparam int IN_TOTAL_LO  = IN_CODE_LO + IDX_W;
    localparam int IN_USED_W    = IN_TOTAL_LO + PIT_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output word layout, lowest bit up
    localparam int OUT_IDX_LO    = 0;
    localparam int OUT_FIRST_LO  = OUT_IDX_LO + IDX_W;
    localparam int OUT_SECOND_LO = OUT_FIRST_LO + PACK_W;
    localparam int OUT_USED_W    = OUT_SECOND_LO + PACK_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // tuser codes
    localparam logic FUNC_RANK   = 1'b0;
    localparam logic FUNC_UNRANK = 1'b1;

    typedef logic [WAYS_W-1:0] t_ways_rom [ROM_DEPTH];

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SUM      = 10'b00_0000_0010,
        S_CHECK    = 10'b00_0000_0100,
        S_RANK_PIT = 10'b00_0000_1000,
        S_RANK_ACC = 10'b00_0001_0000,
        S_UNR_RD   = 10'b00_0010_0000,
        S_UNR_CHK  = 10'b00_0100_0000,
        S_UNR_PIT  = 10'b00_1000_0000,
        S_UNR_CMP  = 10'b01_0000_0000,
        S_FIN      = 10'b10_0000_0000
    } t_state;

    // Pascal-style build of ways(s,p) = C(s+p-1, p-1); p = 0 stays zero
    function automatic t_ways_rom build_ways();
        t_ways_rom tbl;
        int        s;
        int        p;
        for (s = 0; s < ROM_DEPTH; s++) begin
            tbl[s] = '0;
        end
        for (p = 1; p <= PIT_COUNT; p++) begin
            tbl[p] = WAYS_W'(1);
        end
        for (s = 0; s < STONE_ROWS; s++) begin
            tbl[s * (1 << PIDX_W) + 1] = WAYS_W'(1);
        end
        for (p = 2; p <= PIT_COUNT; p++) begin
            for (s = 1; s < STONE_ROWS; s++) begin
                tbl[s * (1 << PIDX_W) + p] = tbl[s * (1 << PIDX_W) + p - 1]
                                           + tbl[(s - 1) * (1 << PIDX_W) + p];
            end
        end
        return tbl;
    endfunction

endpackage

FILE: rtl/core/cru_ways_rom.sv
// ----------------------------------------------------------------------------
// cru_ways_rom
// Constant table of ways(s,p), one registered read per cycle.
// ----------------------------------------------------------------------------
module cru_ways_rom (
    input  logic                        i_clk,
    input  logic [cru_pkg::ROM_AW-1:0]  i_addr,
    output logic [cru_pkg::WAYS_W-1:0]  o_data
);
    import cru_pkg::*;

    localparam t_ways_rom WAYS_ROM = build_ways();

    logic [WAYS_W-1:0] r_data;

    // registered read, address {stones, pits}
    always_ff @(posedge i_clk) begin
        r_data <= WAYS_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: rtl/core/composition_rank_unrank_core.sv
// ----------------------------------------------------------------------------
// composition_rank_unrank_core
// Ranks twelve pit counts to a combinatorial index, or unranks an index and
// stone total back to twelve pit counts.
// ----------------------------------------------------------------------------
// One word at a time. A single ROM read port and one shared 39-bit add/sub
// and compare unit do all the work, one stone at a time. Rank totals the
// twelve pits, then per pit takes one step plus a ROM read and an accumulate
// for each stone in it. Unrank does a range check read, then per pit a read
// and a compare-and-subtract for each stone placed plus a read and compare
// that close the pit. Totals above STONE_LIMIT or an index at or beyond the
// layout count give range_error with all data zero. The result sits in an
// output register, so the next word is taken while it waits.
`include "assert_macros.svh"

module composition_rank_unrank_core #(
    parameter int STONE_LIMIT = cru_pkg::STONE_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // first_side_pits[35:0], second_side_pits[71:36], to_move[72],
    // code_in[111:73], stone_total[117:112], zero pad
    input  logic [cru_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func[0]
    input  logic [0:0]                       i_s_axis_tuser,
    // master side
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // rank_index[38:0], out_first_pits[74:39], out_second_pits[110:75],
    // zero pad
    output logic [cru_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // range_error[0]
    output logic [0:0]                       o_m_axis_tuser
);
    import cru_pkg::*;

    t_state              r_state, n_state;
    logic                r_mode,  n_mode;
    logic [REL_W-1:0]    r_rel,   n_rel;
    logic [IDX_W-1:0]    r_idx,   n_idx;
    logic [SUM_W-1:0]    r_left,  n_left;
    logic [PIDX_W-1:0]   r_pit,   n_pit;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic                r_err,   n_err;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;
    logic                   r_out_err,   n_out_err;

    logic [ROM_AW-1:0]  rom_addr;
    logic [WAYS_W-1:0]  rom_data;

    logic               in_hs;
    logic               out_hs;
    logic [PIT_W-1:0]   cur_pit;
    logic [PIDX_W-1:0]  sub_pits;
    logic [PIT_W-1:0]   left6;
    logic [PIT_W-1:0]   cnt6;
    logic               alu_sub;
    logic [IDX_W-1:0]   alu_w;
    logic [IDX_W-1:0]   alu_sum;
    logic               idx_lt;
    logic [PACK_W-1:0]  in_first;
    logic [PACK_W-1:0]  in_second;

    cru_ways_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign o_s_axis_tready = r_state == S_IDLE;
    assign in_hs           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_hs          = r_out_valid && i_m_axis_tready;

    assign in_first  = i_s_axis_tdata[IN_FIRST_LO  +: PACK_W];
    assign in_second = i_s_axis_tdata[IN_SECOND_LO +: PACK_W];

    assign cur_pit  = r_rel[PIT_W-1:0];
    assign sub_pits = PIDX_W'(LAST_RANKED) - r_pit;
    assign left6    = r_left[PIT_W-1:0];
    assign cnt6     = r_cnt[PIT_W-1:0];

    // shared add/sub and compare against the ROM word
    assign alu_sub = r_state == S_UNR_CMP;
    assign alu_w   = rom_data[IDX_W-1:0];
    assign alu_sum = r_idx + (alu_sub ? ~alu_w : alu_w) + IDX_W'(alu_sub);
    assign idx_lt  = {{(WAYS_W-IDX_W){1'b0}}, r_idx} < rom_data;

    // ROM address per state
    always_comb begin
        rom_addr = '0;
        unique case (r_state)
            S_RANK_PIT: rom_addr = {left6 - cnt6, sub_pits};
            S_UNR_PIT:  rom_addr = {left6 - cnt6, sub_pits};
            S_UNR_RD:   rom_addr = {left6, PIDX_W'(PIT_COUNT)};
            default:    rom_addr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_rel   = r_rel;
        n_idx   = r_idx;
        n_left  = r_left;
        n_pit   = r_pit;
        n_cnt   = r_cnt;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (in_hs) begin
                    n_mode = i_s_axis_tuser[0];
                    n_rel  = i_s_axis_tdata[IN_MOVE_BIT] ? {in_second, in_first}
                                                         : {in_first, in_second};
                    n_idx  = '0;
                    n_left = '0;
                    n_pit  = '0;
                    n_cnt  = '0;
                    n_err  = 1'b0;
                    if (i_s_axis_tuser[0] == FUNC_UNRANK) begin
                        n_idx   = i_s_axis_tdata[IN_CODE_LO +: IDX_W];
                        n_left  = SUM_W'(i_s_axis_tdata[IN_TOTAL_LO +: PIT_W]);
                        n_state = S_UNR_RD;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            // total the pits, rotating the layout back into place
            S_SUM: begin
                n_left = r_left + SUM_W'(cur_pit);
                n_rel  = {cur_pit, r_rel[REL_W-1:PIT_W]};
                n_pit  = r_pit + PIDX_W'(1);
                if (r_pit == PIDX_W'(LAST_RANKED)) begin
                    n_pit   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_left > SUM_W'(STONE_LIMIT)) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_RANK_PIT;
                end
            end
            // one stone per pass; close the pit when all stones counted
            S_RANK_PIT: begin
                if (r_pit == PIDX_W'(LAST_RANKED)) begin
                    n_state = S_FIN;
                end else if (cnt6 == cur_pit) begin
                    n_left = r_left - SUM_W'(cur_pit);
                    n_rel  = {cur_pit, r_rel[REL_W-1:PIT_W]};
                    n_pit  = r_pit + PIDX_W'(1);
                    n_cnt  = '0;
                end else begin
                    n_state = S_RANK_ACC;
                end
            end
            S_RANK_ACC: begin
                n_idx   = alu_sum;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_RANK_PIT;
            end
            S_UNR_RD: begin
                if (r_left > SUM_W'(STONE_LIMIT)) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_UNR_CHK;
                end
            end
            S_UNR_CHK: begin
                if (!idx_lt) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_UNR_PIT;
                end
            end
            // last pit takes the rest; a count past the stones left clamps
            S_UNR_PIT: begin
                if (r_pit == PIDX_W'(LAST_RANKED)) begin
                    n_rel   = {left6, r_rel[REL_W-1:PIT_W]};
                    n_state = S_FIN;
                end else if (r_cnt > CNT_W'(r_left)) begin
                    n_rel  = {left6, r_rel[REL_W-1:PIT_W]};
                    n_left = '0;
                    n_pit  = r_pit + PIDX_W'(1);
                    n_cnt  = '0;
                end else begin
                    n_state = S_UNR_CMP;
                end
            end
            S_UNR_CMP: begin
                if (idx_lt) begin
                    n_rel   = {cnt6, r_rel[REL_W-1:PIT_W]};
                    n_left  = r_left - SUM_W'(r_cnt);
                    n_pit   = r_pit + PIDX_W'(1);
                    n_cnt   = '0;
                end else begin
                    n_idx   = alu_sum;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
                n_state = S_UNR_PIT;
            end
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !out_hs;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        if ((r_state == S_FIN) && (!r_out_valid || i_m_axis_tready)) begin
            n_out_valid = 1'b1;
            n_out_err   = r_err;
            n_out_data  = '0;
            if (!r_err) begin
                if (r_mode == FUNC_RANK) begin
                    n_out_data[OUT_IDX_LO +: IDX_W] = r_idx;
                end else begin
                    n_out_data[OUT_FIRST_LO  +: PACK_W] = r_rel[PACK_W-1:0];
                    n_out_data[OUT_SECOND_LO +: PACK_W] = r_rel[REL_W-1:PACK_W];
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_rel      <= n_rel;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_pit      <= n_pit;
        r_cnt      <= n_cnt;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_err;

    // checks
    `ASSERT_CLK(a_busy_after_accept, in_hs |=> !o_s_axis_tready, "ready right after accept")
    `ASSERT_CLK(a_err_zero_data, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0), "error word carries data")
    `ASSERT_CLK(a_rank_cnt_bound, (r_state == S_RANK_PIT) |-> (r_cnt <= CNT_W'(cur_pit)), "stone count ran past pit")
    `ASSERT_CLK(a_fin_loads_out, ((r_state == S_FIN) && !r_out_valid) |=> o_m_axis_tvalid, "finished word not presented")

endmodule
